>>> rtl/rspf_pkg.sv
`timescale 1ns / 1ps

package rspf_pkg;

	// Width of the in-datagram byte offset and of the header length.
	localparam int unsigned OffW = 19;

	// Fixed RTP header length and the saturation point of the offset counter.
	localparam logic [OffW-1:0] BaseHeader = OffW'(12);
	localparam logic [OffW-1:0] OffsetMax  = {OffW{1'b1}};

	// Bytes of the program stream pack start code.
	localparam logic [7:0] StartZero = 8'h00;
	localparam logic [7:0] StartOne  = 8'h01;
	localparam logic [7:0] PackId    = 8'hBA;

	// Number of payload bytes held in the start code window.
	localparam logic [2:0] WindowLen = 3'd4;

	// Payload word written from the header parser into the queue.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} push_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

>>> rtl/rspf_front.sv
`timescale 1ns / 1ps

module rspf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                datagram_end,
	input  rspf_pkg::qstat_t    qstat,
	output rspf_pkg::push_t     push
);

	logic [rspf_pkg::OffW-1:0] off_q, off_n;
	logic [rspf_pkg::OffW-1:0] hdr_q, hdr_n;
	logic                      ext_q, ext_n;
	logic [7:0]                ext_hi_q, ext_hi_n;
	logic                      payload;
	logic                      accept;

	// A word is taken whenever the queue has room.
	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	// Header parsing: work out the header length and classify the word.
	always_comb begin
		off_n    = off_q;
		hdr_n    = hdr_q;
		ext_n    = ext_q;
		ext_hi_n = ext_hi_q;
		payload  = 1'b0;
		if (off_q == '0) begin
			hdr_n = rspf_pkg::BaseHeader + {13'b0, data_byte[3:0], 2'b00};
			ext_n = data_byte[4];
		end else if (ext_q) begin
			if (off_q == hdr_q + 19'd2) begin
				ext_hi_n = data_byte;
			end else if (off_q == hdr_q + 19'd3) begin
				hdr_n = hdr_q + 19'd4 + {1'b0, ext_hi_q, data_byte, 2'b00};
				ext_n = 1'b0;
			end
		end else if (off_q >= hdr_q) begin
			payload = 1'b1;
		end
		if (datagram_end) begin
			off_n    = '0;
			hdr_n    = rspf_pkg::BaseHeader;
			ext_n    = 1'b0;
			ext_hi_n = '0;
		end else if (off_q != rspf_pkg::OffsetMax) begin
			off_n = off_q + 19'd1;
		end
	end

	// Parser state advances on every accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= '0;
			hdr_q    <= rspf_pkg::BaseHeader;
			ext_q    <= 1'b0;
			ext_hi_q <= '0;
		end else if (accept) begin
			off_q    <= off_n;
			hdr_q    <= hdr_n;
			ext_q    <= ext_n;
			ext_hi_q <= ext_hi_n;
		end
	end

	// Only payload words enter the queue.
	assign push.valid = accept && payload;
	assign push.data  = data_byte;

endmodule

>>> rtl/rspf_fifo.sv
`timescale 1ns / 1ps

module rspf_fifo #(
	parameter int unsigned Depth = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rspf_pkg::push_t    push,
	input  logic               pop,
	output logic [7:0]         rd_data,
	output rspf_pkg::qstat_t   qstat
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	logic [7:0]      mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign qstat.full  = (count_q == FullCnt);
	assign qstat.empty = (count_q == '0);
	assign rd_data     = mem_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	// Pointers wrap at the depth; the count tracks the fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/rspf_back.sv
`timescale 1ns / 1ps

module rspf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rspf_pkg::qstat_t    qstat,
	input  logic [7:0]          rd_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          pack_byte,
	output logic                pack_last
);

	logic [7:0] hist_q [4];
	logic [2:0] fill_q;
	logic [2:0] fill_n;
	logic       inside_q;
	logic       had_out;
	logic       match;
	logic       emit;
	logic       out_valid_q;
	logic [7:0] pack_byte_q;
	logic       pack_last_q;

	// Take a payload word when one is queued and the output register is free.
	assign pop = !qstat.empty && (!out_valid_q || out_ready);

	// Start code search over the window after the new word is shifted in.
	always_comb begin
		had_out = (fill_q >= rspf_pkg::WindowLen);
		fill_n  = had_out ? fill_q : fill_q + 3'd1;
		match   = (fill_n >= rspf_pkg::WindowLen) &&
		          (hist_q[1] == rspf_pkg::StartZero) &&
		          (hist_q[2] == rspf_pkg::StartZero) &&
		          (hist_q[3] == rspf_pkg::StartOne) &&
		          (rd_data == rspf_pkg::PackId);
		emit    = had_out && inside_q;
	end

	// Window contents need no reset; the fill count guards them.
	always_ff @(posedge clk) begin
		if (pop) begin
			hist_q[0] <= hist_q[1];
			hist_q[1] <= hist_q[2];
			hist_q[2] <= hist_q[3];
			hist_q[3] <= rd_data;
		end
		if (pop && emit) begin
			pack_byte_q <= hist_q[0];
			pack_last_q <= match;
		end
	end

	// Window fill, pack tracking and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			inside_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				fill_q   <= fill_n;
				inside_q <= inside_q || match;
			end
			if (pop) begin
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pack_byte = pack_byte_q;
	assign pack_last = pack_last_q;

endmodule

>>> rtl/rtp_strip_ps_pack_framer.sv
`timescale 1ns / 1ps

// RTP depacketiser and program stream pack framer.
// The input channel (in_valid/in_ready, data_byte, datagram_end) takes one
// datagram word per cycle while the queue has room, datagram_end high on
// the last word of a datagram. The header parser strips each RTP header
// (fixed part, CSRC list and extension) and writes payload words into a
// small queue of FifoDepth words. The framer behind the queue joins the
// payloads into one stream, searches for the pack start code 00 00 01 BA
// and sends each pack on the output channel (out_valid/out_ready,
// pack_byte, pack_last), pack_last high on the word just before the next
// start code. Data before the first start code is never sent; the last four
// payload words stay in the window. Throughput is one word per cycle on
// both sides while neither side stalls. A pack word leaves once four more
// payload words have arrived, in the cycle after the queue read of the fourth.
// When the receiver stalls, the output register holds its word and the queue
// fills; in_ready falls only once the queue is full.
// Reset empties the queue and the output register, forgets the start code
// window and returns the parser to the first word of a datagram.
module rtp_strip_ps_pack_framer #(
	parameter int unsigned FifoDepth = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       datagram_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] pack_byte,
	output logic       pack_last
);

	rspf_pkg::push_t  push;
	rspf_pkg::qstat_t qstat;
	logic             pop;
	logic [7:0]       rd_data;

	// Header parser.
	rspf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.datagram_end (datagram_end),
		.qstat        (qstat),
		.push         (push)
	);

	// Payload queue between parser and framer.
	rspf_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.rd_data (rd_data),
		.qstat   (qstat)
	);

	// Start code search and pack output.
	rspf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.rd_data   (rd_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pack_byte (pack_byte),
		.pack_last (pack_last)
	);

	// The framer never reads an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !qstat.empty)
		else $error("queue read while empty");

	// The parser never writes a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) push.valid |-> !qstat.full)
		else $error("queue written while full");

	// A stalled output word is not overwritten by a queue read.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !pop)
		else $error("output register overwritten during stall");

endmodule

>>> tb/sv/rtp_strip_ps_pack_framer_tb.sv
`timescale 1ns / 1ps

module rtp_strip_ps_pack_framer_tb;

	// RTP header layout and program stream start code bytes.
	localparam logic [1:0]  RtpVersion  = 2'b10;
	localparam logic [18:0] HdrLenFixed = 19'd12;
	localparam logic [18:0] OffsetSat   = 19'h7FFFF;
	localparam logic [7:0]  CodeZero    = 8'h00;
	localparam logic [7:0]  CodeOne     = 8'h01;
	localparam logic [7:0]  CodePack    = 8'hBA;
	localparam int          WatchdogLimit = 2000;
	localparam int          DrainCycles   = 16;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} pack_word_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       datagram_end;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] pack_byte;
	logic       pack_last;

	// Predicted framer state.
	logic [18:0] exp_offset;
	logic [18:0] exp_hdr_len;
	logic        exp_ext_open;
	logic [7:0]  exp_ext_hi;
	logic [7:0]  exp_window[4];
	int          exp_fill;
	logic        exp_in_pack;

	pack_word_t  pack_words_due[$];
	pack_word_t  got_word;
	byte_q_t     ps_stream;
	int          mismatches = 0;
	int          payload_words = 0;
	int          quiet_cycles = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          rx_hold = 0;

	rtp_strip_ps_pack_framer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.datagram_end(datagram_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pack_byte   (pack_byte),
		.pack_last   (pack_last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Clears the predicted header parser, start code window and pack flag.
	function automatic void clear_prediction();
		exp_offset   = '0;
		exp_hdr_len  = HdrLenFixed;
		exp_ext_open = 1'b0;
		exp_ext_hi   = '0;
		exp_window   = '{default: '0};
		exp_fill     = 0;
		exp_in_pack  = 1'b0;
	endfunction

	// Works out the pack word, if any, that one accepted datagram word releases.
	function automatic void predict_pack_words(input logic [7:0] b, input logic eod);
		logic [18:0] off;
		logic        is_payload;
		logic        had_out;
		logic        found;
		logic [7:0]  outgoing;

		off = exp_offset;
		is_payload = 1'b0;

		// Header parsing: CSRC count and extension flag in byte 0, extension
		// length in the third and fourth bytes after the CSRC list.
		if (off == 0) begin
			exp_hdr_len  = 19'(HdrLenFixed + 4 * b[3:0]);
			exp_ext_open = b[4];
		end else if (exp_ext_open) begin
			if (off == exp_hdr_len + 2) begin
				exp_ext_hi = b;
			end else if (off == exp_hdr_len + 3) begin
				exp_hdr_len  = 19'(exp_hdr_len + 4 + 4 * {exp_ext_hi, b});
				exp_ext_open = 1'b0;
			end
		end else if (off >= exp_hdr_len) begin
			is_payload = 1'b1;
		end

		// Four-word delay line with start code search over its contents.
		if (is_payload) begin
			had_out  = exp_fill >= 4;
			outgoing = exp_window[0];
			exp_window[0] = exp_window[1];
			exp_window[1] = exp_window[2];
			exp_window[2] = exp_window[3];
			exp_window[3] = b;
			if (exp_fill < 4)
				exp_fill++;
			found = exp_fill >= 4 && exp_window[0] == CodeZero && exp_window[1] == CodeZero
				&& exp_window[2] == CodeOne && exp_window[3] == CodePack;
			if (had_out && exp_in_pack)
				pack_words_due.push_back('{data: outgoing, last: found});
			if (found)
				exp_in_pack = 1'b1;
		end

		// The offset restarts on each datagram and sticks at its maximum.
		if (eod) begin
			exp_offset   = '0;
			exp_hdr_len  = HdrLenFixed;
			exp_ext_open = 1'b0;
			exp_ext_hi   = '0;
		end else if (off < OffsetSat) begin
			exp_offset = off + 1;
		end
	endfunction

	// Appends one pack (start code and a short random body) to the stream.
	function automatic void grow_ps_stream();
		int body_len;

		body_len = $urandom_range(28);
		ps_stream.push_back(CodeZero);
		ps_stream.push_back(CodeZero);
		ps_stream.push_back(CodeOne);
		ps_stream.push_back(CodePack);
		repeat (body_len) begin
			case ($urandom_range(9))
				0: begin
					// Near miss: the prefix with a random stream id.
					ps_stream.push_back(CodeZero);
					ps_stream.push_back(CodeZero);
					ps_stream.push_back(CodeOne);
					ps_stream.push_back(8'($urandom));
				end
				1: begin
					ps_stream.push_back(CodeZero);
					ps_stream.push_back(CodeOne);
					ps_stream.push_back(CodePack);
				end
				default: ps_stream.push_back(($urandom_range(3) == 0) ? CodeZero : 8'($urandom));
			endcase
		end
	endfunction

	function automatic byte_q_t take_ps(input int n);
		byte_q_t chunk;

		repeat (n) begin
			if (ps_stream.size() == 0)
				grow_ps_stream();
			chunk.push_back(ps_stream.pop_front());
		end
		return chunk;
	endfunction

	// Offers one datagram word and waits until it is taken.
	task automatic send_word(input logic [7:0] b, input logic eod);
		logic taken;

		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		data_byte    <= b;
		datagram_end <= eod;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		predict_pack_words(b, eod);
	endtask

	// Builds one RTP datagram around the payload. A non-zero cut_len ends the
	// datagram early, after that many words.
	task automatic send_rtp(input int csrc_n, input logic with_ext, input int ext_words,
		input byte_q_t payload, input int cut_len);
		byte_q_t frame;
		int      hdr;
		int      total;

		frame.push_back({RtpVersion, 1'($urandom_range(1)), with_ext, 4'(csrc_n)});
		repeat (11 + 4 * csrc_n)
			frame.push_back(8'($urandom));
		if (with_ext) begin
			frame.push_back(8'($urandom));
			frame.push_back(8'($urandom));
			frame.push_back(8'(ext_words >> 8));
			frame.push_back(8'(ext_words));
			repeat (4 * ext_words)
				frame.push_back(8'($urandom));
		end
		hdr = frame.size();
		frame = {frame, payload};
		total = (cut_len > 0 && cut_len < frame.size()) ? cut_len : frame.size();
		for (int i = 0; i < total; i++)
			send_word(frame[i], i == total - 1);
		if (total > hdr)
			payload_words += total - hdr;
	endtask

	// Stops offering and waits for every predicted pack word.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pack_words_due.size() != 0);
	endtask

	task automatic send_random_datagram();
		int      kind;
		int      csrc_n;
		logic    with_ext;
		int      ext_words;
		byte_q_t noise;

		kind      = $urandom_range(99);
		csrc_n    = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
		with_ext  = ($urandom_range(3) == 0);
		ext_words = ($urandom_range(4) == 0) ? $urandom_range(8) : $urandom_range(2);
		if (kind < 80) begin
			send_rtp(csrc_n, with_ext, ext_words, take_ps($urandom_range(48)), 0);
		end else if (kind < 92) begin
			// Datagram that ends somewhere inside its own header.
			send_rtp(csrc_n, with_ext, ext_words, noise,
				$urandom_range(12 + 4 * csrc_n + (with_ext ? 4 + 4 * ext_words : 0), 1));
		end else begin
			// Raw noise, first byte included.
			repeat ($urandom_range(20, 1))
				noise.push_back(8'($urandom));
			for (int i = 0; i < noise.size(); i++)
				send_word(noise[i], i == noise.size() - 1);
		end
	endtask

	// Datagrams cut off at byte 0, inside the extension and inside the fixed header.
	task automatic test_short_datagrams();
		byte_q_t none;

		send_rtp(15, 1'b1, 0, none, 1);
		send_rtp(0, 1'b1, 1, none, 14);
		send_rtp(2, 1'b0, 0, none, 5);
		wait_drained();
	endtask

	// Leading garbage, a start code split over datagrams, an empty payload
	// and a pack made of nothing but its start code.
	task automatic test_pack_framing();
		byte_q_t none;

		send_rtp(0, 1'b0, 0, '{8'hAA, CodeZero, CodeZero, CodeOne, CodePack, 8'h00, 8'hFF}, 0);
		send_rtp(15, 1'b0, 0, '{CodeZero, CodeZero, CodeOne}, 0);
		send_rtp(1, 1'b1, 0, none, 0);
		send_rtp(0, 1'b0, 0, '{CodePack, CodeZero, CodeZero, CodeOne, CodePack, 8'h7E}, 0);
		wait_drained();
	endtask

	// Full CSRC list and a long extension ahead of the payload, with a start
	// code a few words into it.
	task automatic test_long_datagram();
		byte_q_t body;

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		repeat (4)
			body.push_back(8'($urandom));
		body = {body, CodeZero, CodeZero, CodeOne, CodePack, 8'h55, 8'h66};
		send_rtp(15, 1'b1, 12, body, 0);
		wait_drained();
	endtask

	// The receiver holds off while the sender keeps offering, so the queue
	// fills and the input stalls.
	task automatic test_output_hold_off();
		rx_hold = 200;
		send_rtp(0, 1'b0, 0, take_ps(60), 0);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int target;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
				default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
			endcase
			target = payload_words + 48;
			while (payload_words < target)
				send_random_datagram();
			wait_drained();
		end
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				rx_hold--;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Compares each pack word that is about to be taken with the oldest prediction.
	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pack_words_due.size() == 0) begin
				$error("pack_byte: no word expected, got %02h", pack_byte);
				mismatches++;
			end else begin
				got_word = pack_words_due.pop_front();
				if (pack_byte !== got_word.data) begin
					$error("pack_byte: expected %02h, got %02h", got_word.data, pack_byte);
					mismatches++;
				end
				if (pack_last !== got_word.last) begin
					$error("pack_last: expected %0b, got %0b", got_word.last, pack_last);
					mismatches++;
				end
			end
		end
	end

	// Ends the run when no word moves on either side for too long.
	always @(negedge clk) begin
		if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		data_byte    = '0;
		datagram_end = 1'b0;
		clear_prediction();
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_datagrams();
		test_pack_framing();
		test_output_hold_off();
		test_random_traffic();
		test_long_datagram();

		wait_drained();
		repeat (DrainCycles)
			@(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
rtl/rspf_pkg.sv
rtl/rspf_front.sv
rtl/rspf_fifo.sv
rtl/rspf_back.sv
rtl/rtp_strip_ps_pack_framer.sv
tb/sv/rtp_strip_ps_pack_framer_tb.sv
